### rtl/dpbp_pkg.sv
// shared types and constants for the depth pixel back-projection block
`timescale 1ns / 1ps

package dpbp_pkg;

  // coordinate width default, handed to the top level parameter
  localparam int COORD_BITS_DEF = 12;

  // fixed field widths
  localparam int CAMERA_W   = 4;
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int INV_W      = 24;
  localparam int CENTER_W   = 16;
  localparam int POINT_W    = 32;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_SHIFT = 24;

  // register stages through one axis unit, input to result
  localparam int AXIS_LAT = 5;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_INV_FOCAL_X = 2'd0,
    REG_INV_FOCAL_Y = 2'd1,
    REG_CENTER_X    = 2'd2,
    REG_CENTER_Y    = 2'd3
  } reg_idx_t;

  // configuration reset values
  localparam logic [INV_W-1:0]    INV_FOCAL_X_RST = 24'd33554;
  localparam logic [INV_W-1:0]    INV_FOCAL_Y_RST = 24'd33554;
  localparam logic [CENTER_W-1:0] CENTER_X_RST    = 16'd5120;
  localparam logic [CENTER_W-1:0] CENTER_Y_RST    = 16'd3840;

  // fields that ride alongside the axis units
  typedef struct packed {
    logic [CAMERA_W-1:0] camera;
    logic [DEPTH_W-1:0]  depth;
    logic                depth_nz;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } side_t;

endpackage

### rtl/dpbp_axis.sv
// one axis of the projection: ((coord << 4) - center) * depth * inv >> 24, saturated
`timescale 1ns / 1ps

module dpbp_axis #(
  parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic [COORD_BITS-1:0]               coord,
  input  logic [dpbp_pkg::CENTER_W-1:0]       center,
  input  logic [dpbp_pkg::DEPTH_W-1:0]        depth,
  input  logic [dpbp_pkg::INV_W-1:0]          inv,
  output logic signed [dpbp_pkg::POINT_W-1:0] point
);
  import dpbp_pkg::*;

  localparam int C4_W  = COORD_BITS + 4;
  localparam int MAG_W = (C4_W > CENTER_W) ? C4_W : CENTER_W;
  localparam int P1_W  = MAG_W + DEPTH_W;
  localparam int P2_W  = P1_W + INV_W;
  localparam int SUM_W = P2_W + 1;
  localparam int QM_W  = SUM_W - FRAC_SHIFT;

  localparam logic [QM_W-1:0] POS_LIM = QM_W'({1'b0, {(POINT_W-1){1'b1}}});
  localparam logic [QM_W-1:0] NEG_LIM = QM_W'({1'b1, {(POINT_W-1){1'b0}}});
  localparam logic [SUM_W-1:0] ROUND_ADD = SUM_W'({FRAC_SHIFT{1'b1}});

  // stage 1: signed offset split into sign and magnitude
  logic [MAG_W:0]         c4_w, ctr_w, d_pos, d_neg;
  logic                   neg1_nxt;
  logic [MAG_W-1:0]       mag_nxt;
  logic [MAG_W-1:0]       mag_r;
  logic [DEPTH_W-1:0]     depth1_r;
  logic                   neg1_r;

  assign c4_w     = (MAG_W+1)'({coord, 4'b0000});
  assign ctr_w    = (MAG_W+1)'(center);
  assign d_pos    = c4_w - ctr_w;
  assign d_neg    = ctr_w - c4_w;
  assign neg1_nxt = d_pos[MAG_W];
  assign mag_nxt  = neg1_nxt ? d_neg[MAG_W-1:0] : d_pos[MAG_W-1:0];

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    depth1_r <= depth;
    neg1_r   <= neg1_nxt;
  end

  // stage 2: magnitude times depth
  logic [P1_W-1:0] p1_nxt, p1_r;
  logic            neg2_r;

  assign p1_nxt = P1_W'(mag_r) * P1_W'(depth1_r);

  always_ff @(posedge clk) begin
    p1_r   <= p1_nxt;
    neg2_r <= neg1_r;
  end

  // stage 3: times the reciprocal focal length
  logic [P2_W-1:0] p2_nxt, p2_r;
  logic            neg3_r;

  assign p2_nxt = P2_W'(p1_r) * P2_W'(inv);

  always_ff @(posedge clk) begin
    p2_r   <= p2_nxt;
    neg3_r <= neg2_r;
  end

  // stage 4: drop the fraction, rounding the magnitude up for negatives (floor)
  logic [SUM_W-1:0] sum_w;
  logic [QM_W-1:0]  qm_r;
  logic             neg4_r;

  assign sum_w = SUM_W'(p2_r) + (neg3_r ? ROUND_ADD : '0);

  always_ff @(posedge clk) begin
    qm_r   <= sum_w[SUM_W-1:FRAC_SHIFT];
    neg4_r <= neg3_r;
  end

  // stage 5: restore sign and clamp to 32 bits
  logic [POINT_W-1:0] point_nxt, point_r;

  always_comb begin
    if (neg4_r) begin
      if (qm_r > NEG_LIM) begin
        point_nxt = {1'b1, {(POINT_W-1){1'b0}}};
      end else begin
        point_nxt = ~qm_r[POINT_W-1:0] + POINT_W'(1);
      end
    end else begin
      if (qm_r > POS_LIM) begin
        point_nxt = {1'b0, {(POINT_W-1){1'b1}}};
      end else begin
        point_nxt = qm_r[POINT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    point_r <= point_nxt;
  end

  assign point = signed'(point_r);

endmodule

### rtl/depth_pixel_back_projection.sv
// top level: pinhole back-projection of a depth pixel stream into 3-D points
`timescale 1ns / 1ps

// Takes one depth pixel per clock (start high; busy is always low) and gives the
// back-projected point on the out_ ports, marked by a one-cycle out_valid strobe,
// after the five register stages of each axis unit (offset, two multiplies,
// rounding, saturation). The rate is one transaction per clock. Results cannot be
// held off: the receiver must take each one in the cycle it is shown. x and y
// are signed Q.4, floored and clamped to 32 bits; a depth of zero gives
// point_valid = 0 and zero coordinates, while camera number and colour always
// pass through. Configuration writes take effect at once and must be made only
// while no transaction is in flight.
module depth_pixel_back_projection #(
  parameter int COORD_BITS = dpbp_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  dpbp_pkg::reg_idx_t                   cfg_index,
  input  logic [dpbp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input transaction
  input  logic                                 start,
  output logic                                 busy,
  input  logic [dpbp_pkg::CAMERA_W-1:0]        in_camera,
  input  logic [COORD_BITS-1:0]                in_column,
  input  logic [COORD_BITS-1:0]                in_line,
  input  logic [dpbp_pkg::DEPTH_W-1:0]         in_depth,
  input  logic [dpbp_pkg::COLOR_W-1:0]         in_red,
  input  logic [dpbp_pkg::COLOR_W-1:0]         in_green,
  input  logic [dpbp_pkg::COLOR_W-1:0]         in_blue,
  // result transaction
  output logic                                 out_valid,
  output logic [dpbp_pkg::CAMERA_W-1:0]        out_camera_out,
  output logic                                 out_point_valid,
  output logic signed [dpbp_pkg::POINT_W-1:0]  out_point_x,
  output logic signed [dpbp_pkg::POINT_W-1:0]  out_point_y,
  output logic [dpbp_pkg::DEPTH_W-1:0]         out_point_z,
  output logic [dpbp_pkg::COLOR_W-1:0]         out_red_out,
  output logic [dpbp_pkg::COLOR_W-1:0]         out_green_out,
  output logic [dpbp_pkg::COLOR_W-1:0]         out_blue_out
);
  import dpbp_pkg::*;

  // configuration registers
  logic [INV_W-1:0]    inv_fx_r, inv_fy_r;
  logic [CENTER_W-1:0] ctr_x_r, ctr_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_fx_r <= INV_FOCAL_X_RST;
      inv_fy_r <= INV_FOCAL_Y_RST;
      ctr_x_r  <= CENTER_X_RST;
      ctr_y_r  <= CENTER_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_FOCAL_X: inv_fx_r <= cfg_data[INV_W-1:0];
        REG_INV_FOCAL_Y: inv_fy_r <= cfg_data[INV_W-1:0];
        REG_CENTER_X:    ctr_x_r  <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:    ctr_y_r  <= cfg_data[CENTER_W-1:0];
        default:         ;
      endcase
    end
  end

  // the pipeline never stalls, so a new transaction is taken every cycle that start is high
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid bits and pass-through fields, matched to the axis unit latency
  logic [AXIS_LAT-1:0] vld_r;
  side_t               side_r [AXIS_LAT];
  side_t               side_in;

  assign side_in.camera   = in_camera;
  assign side_in.depth    = in_depth;
  assign side_in.depth_nz = (in_depth != '0);
  assign side_in.red      = in_red;
  assign side_in.green    = in_green;
  assign side_in.blue     = in_blue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[AXIS_LAT-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side_in;
    for (int i = 1; i < AXIS_LAT; i++) begin
      side_r[i] <= side_r[i-1];
    end
  end

  // one arithmetic pipe per axis
  logic signed [POINT_W-1:0] px, py;

  dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk    (clk),
    .coord  (in_column),
    .center (ctr_x_r),
    .depth  (in_depth),
    .inv    (inv_fx_r),
    .point  (px)
  );

  dpbp_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk    (clk),
    .coord  (in_line),
    .center (ctr_y_r),
    .depth  (in_depth),
    .inv    (inv_fy_r),
    .point  (py)
  );

  // result ports, coordinates forced to zero for missing depth
  side_t side_out;

  assign side_out        = side_r[AXIS_LAT-1];
  assign out_valid       = vld_r[AXIS_LAT-1];
  assign out_camera_out  = side_out.camera;
  assign out_point_valid = side_out.depth_nz;
  assign out_point_x     = side_out.depth_nz ? px : '0;
  assign out_point_y     = side_out.depth_nz ? py : '0;
  assign out_point_z     = side_out.depth_nz ? side_out.depth : '0;
  assign out_red_out     = side_out.red;
  assign out_green_out   = side_out.green;
  assign out_blue_out    = side_out.blue;

  // every result traces back to an earlier accepted transaction, through the valid shift register
  a_out_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, AXIS_LAT))
    else $error("result without matching input transaction");

  // every accepted transaction produces a result at the end of the valid shift register
  a_accept_to_out : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##AXIS_LAT out_valid)
    else $error("input transaction lost in pipeline");

  // point_valid and z follow the depth of the matching input
  a_valid_depth : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_point_valid == ($past(in_depth, AXIS_LAT) != '0)) &&
                  (out_point_z == $past(in_depth, AXIS_LAT)))
    else $error("point_valid or z out of step with input depth");

endmodule
